// ----- hw/rtl/asac_pkg.sv -----
`timescale 1ns / 1ps
// Package for the air sample averager and classifier.
// Window and drop counts, field widths, register indexes, threshold reset values and class codes.
// No dependencies.
package asac_pkg;

    localparam int WINDOW_COUNT_DEF = 8;
    localparam int DROP_COUNT       = 2;

    localparam int CO2_W   = 16;
    localparam int TEMP_W  = 15;
    localparam int HUMID_W = 14;
    localparam int THR_W   = 16;
    localparam int CLASS_W = 3;

    localparam int NUM_THR   = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_THR_UNKNOWN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_EXCELLENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_GOOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FAIR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_INFERIOR  = 3'd4;

    localparam logic [THR_W-1:0] THR_UNKNOWN_RST   = 16'd0;
    localparam logic [THR_W-1:0] THR_EXCELLENT_RST = 16'd600;
    localparam logic [THR_W-1:0] THR_GOOD_RST      = 16'd800;
    localparam logic [THR_W-1:0] THR_FAIR_RST      = 16'd1000;
    localparam logic [THR_W-1:0] THR_INFERIOR_RST  = 16'd1500;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_UNKNOWN   = 3'd0,
        CLASS_EXCELLENT = 3'd1,
        CLASS_GOOD      = 3'd2,
        CLASS_FAIR      = 3'd3,
        CLASS_INFERIOR  = 3'd4,
        CLASS_POOR      = 3'd5
    } quality_class_t;

endpackage

// ----- hw/rtl/air_sample_averager_classifier.sv -----
`timescale 1ns / 1ps
// Air sample averager and classifier: windowed sensor means, air-quality
// class and running CO2 peak. Depends on asac_pkg.
//
//  channel  direction  handshake                    payload
//  s_       in         s_valid / s_ready            co2_ppm, temp_centi, humid_centi, read_error
//  m_       out        m_valid / m_ready            mean_co2, mean_temp, mean_humid,
//                                                   quality_class, peak_co2
//  cfg_     in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One reading is accepted per cycle while s_ready is high. The reading that closes a
// window loads a snapshot register when it is accepted; the means, class and peak
// then move from the snapshot into the result register once the result register is free.
// Sustained rate is set by the snapshot and result registers: one item a cycle while m_ready holds.
// Reset is synchronous; no clearing pass.
// A stalled result holds the result register; readings keep flowing until a
// closing reading fills the snapshot behind it, then s_ready stays low until
// the result request is taken.
module air_sample_averager_classifier #(
    parameter int WINDOW_COUNT = asac_pkg::WINDOW_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [asac_pkg::CO2_W-1:0]            s_co2_ppm,
    input  logic signed [asac_pkg::TEMP_W-1:0]    s_temp_centi,
    input  logic [asac_pkg::HUMID_W-1:0]          s_humid_centi,
    input  logic                                  s_read_error,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [asac_pkg::CO2_W-1:0]            m_mean_co2,
    output logic signed [asac_pkg::TEMP_W-1:0]    m_mean_temp,
    output logic [asac_pkg::HUMID_W-1:0]          m_mean_humid,
    output logic [asac_pkg::CLASS_W-1:0]          m_quality_class,
    output logic [asac_pkg::CO2_W-1:0]            m_peak_co2,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [asac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [asac_pkg::THR_W-1:0]            cfg_data
);
    import asac_pkg::*;

    localparam int WIN_LOG  = $clog2(WINDOW_COUNT);
    localparam int CO2_SW   = CO2_W + WIN_LOG;
    localparam int TEMP_SW  = TEMP_W + WIN_LOG;
    localparam int HUMID_SW = HUMID_W + WIN_LOG;
    localparam int IDX_W    = $clog2(WINDOW_COUNT + DROP_COUNT);

    localparam logic [IDX_W-1:0] DROP_IDX = IDX_W'(DROP_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_COUNT + DROP_COUNT - 1);

    // Reciprocal multipliers: floor(x / WINDOW_COUNT) == (x * MUL) >> SH
    // for every x below 2**SW.
    localparam int CO2_SH   = CO2_SW + WIN_LOG;
    localparam int CO2_MW   = CO2_SW + 2;
    localparam int TEMP_SH  = TEMP_SW + WIN_LOG;
    localparam int TEMP_MW  = TEMP_SW + 2;
    localparam int HUMID_SH = HUMID_SW + WIN_LOG;
    localparam int HUMID_MW = HUMID_SW + 2;
    localparam logic [CO2_MW-1:0] CO2_MUL =
        CO2_MW'(((64'd1 << CO2_SH) + WINDOW_COUNT - 1) / WINDOW_COUNT);
    localparam logic [TEMP_MW-1:0] TEMP_MUL =
        TEMP_MW'(((64'd1 << TEMP_SH) + WINDOW_COUNT - 1) / WINDOW_COUNT);
    localparam logic [HUMID_MW-1:0] HUMID_MUL =
        HUMID_MW'(((64'd1 << HUMID_SH) + WINDOW_COUNT - 1) / WINDOW_COUNT);

    // configuration
    logic [THR_W-1:0] thr_reg [NUM_THR];

    // window state
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CO2_SW-1:0]         co2_sum_reg, co2_sum_next, co2_add;
    logic signed [TEMP_SW-1:0] temp_sum_reg, temp_sum_next, temp_add;
    logic [HUMID_SW-1:0]       humid_sum_reg, humid_sum_next, humid_add;

    // snapshot stage
    logic                      b_valid_reg, b_valid_next;
    logic [CO2_SW-1:0]         b_co2_sum_reg;
    logic signed [TEMP_SW-1:0] b_temp_sum_reg;
    logic [HUMID_SW-1:0]       b_humid_sum_reg;

    // result stage
    logic                      m_valid_reg, m_valid_next;
    logic [CO2_W-1:0]          m_mean_co2_reg;
    logic signed [TEMP_W-1:0]  m_mean_temp_reg;
    logic [HUMID_W-1:0]        m_mean_humid_reg;
    quality_class_t            m_class_reg;
    logic [CO2_W-1:0]          peak_reg, peak_next;

    logic s_fire, c_ready, b_move, kept, emit;

    logic [CO2_SW+CO2_MW-1:0]     co2_prod;
    logic [TEMP_SW-1:0]           temp_mag;
    logic [TEMP_SW+TEMP_MW-1:0]   temp_prod;
    logic [TEMP_W-1:0]            temp_quot;
    logic [HUMID_SW+HUMID_MW-1:0] humid_prod;
    logic [CO2_W-1:0]             mean_co2;
    logic signed [TEMP_W-1:0]     mean_temp;
    logic [HUMID_W-1:0]           mean_humid;
    quality_class_t               class_next;

    // handshakes
    assign cfg_ready = 1'b1;
    assign c_ready   = !m_valid_reg || m_ready;
    assign s_ready   = !b_valid_reg || c_ready;
    assign s_fire    = s_valid && s_ready;
    assign b_move    = b_valid_reg && c_ready;

    // window accumulation
    assign kept      = !s_read_error && (idx_reg >= DROP_IDX);
    assign emit      = s_read_error || (kept && (idx_reg == LAST_IDX));
    assign co2_add   = co2_sum_reg + CO2_SW'(s_co2_ppm);
    assign temp_add  = temp_sum_reg + TEMP_SW'(s_temp_centi);
    assign humid_add = humid_sum_reg + HUMID_SW'(s_humid_centi);

    always_comb begin
        idx_next       = idx_reg;
        co2_sum_next   = co2_sum_reg;
        temp_sum_next  = temp_sum_reg;
        humid_sum_next = humid_sum_reg;
        if (s_fire) begin
            if (emit) begin
                idx_next       = '0;
                co2_sum_next   = '0;
                temp_sum_next  = '0;
                humid_sum_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (kept) begin
                    co2_sum_next   = co2_add;
                    temp_sum_next  = temp_add;
                    humid_sum_next = humid_add;
                end
            end
        end
    end

    always_comb begin
        if (s_fire && emit) begin
            b_valid_next = 1'b1;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    // means by reciprocal multiply; temperature goes through its magnitude
    assign co2_prod  = (CO2_SW+CO2_MW)'(b_co2_sum_reg) * (CO2_SW+CO2_MW)'(CO2_MUL);
    assign mean_co2  = co2_prod[CO2_SH +: CO2_W];
    assign temp_mag  = b_temp_sum_reg[TEMP_SW-1] ? (~b_temp_sum_reg + 1'b1) : b_temp_sum_reg;
    assign temp_prod = (TEMP_SW+TEMP_MW)'(temp_mag) * (TEMP_SW+TEMP_MW)'(TEMP_MUL);
    assign temp_quot = temp_prod[TEMP_SH +: TEMP_W];
    assign mean_temp = b_temp_sum_reg[TEMP_SW-1] ? -$signed(temp_quot) : $signed(temp_quot);
    assign humid_prod = (HUMID_SW+HUMID_MW)'(b_humid_sum_reg)
                      * (HUMID_SW+HUMID_MW)'(HUMID_MUL);
    assign mean_humid = humid_prod[HUMID_SH +: HUMID_W];

    // first threshold that holds decides the class
    always_comb begin
        if (mean_co2 <= thr_reg[REG_THR_UNKNOWN]) begin
            class_next = CLASS_UNKNOWN;
        end else if (mean_co2 <= thr_reg[REG_THR_EXCELLENT]) begin
            class_next = CLASS_EXCELLENT;
        end else if (mean_co2 <= thr_reg[REG_THR_GOOD]) begin
            class_next = CLASS_GOOD;
        end else if (mean_co2 <= thr_reg[REG_THR_FAIR]) begin
            class_next = CLASS_FAIR;
        end else if (mean_co2 <= thr_reg[REG_THR_INFERIOR]) begin
            class_next = CLASS_INFERIOR;
        end else begin
            class_next = CLASS_POOR;
        end
    end

    always_comb begin
        peak_next = peak_reg;
        if (b_move && (mean_co2 > peak_reg)) begin
            peak_next = mean_co2;
        end
    end

    always_comb begin
        if (b_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            co2_sum_reg   <= '0;
            temp_sum_reg  <= '0;
            humid_sum_reg <= '0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            peak_reg      <= '0;
        end else begin
            idx_reg       <= idx_next;
            co2_sum_reg   <= co2_sum_next;
            temp_sum_reg  <= temp_sum_next;
            humid_sum_reg <= humid_sum_next;
            b_valid_reg   <= b_valid_next;
            m_valid_reg   <= m_valid_next;
            peak_reg      <= peak_next;
        end
    end

    // threshold registers; writes beyond the last index drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg[REG_THR_UNKNOWN]   <= THR_UNKNOWN_RST;
            thr_reg[REG_THR_EXCELLENT] <= THR_EXCELLENT_RST;
            thr_reg[REG_THR_GOOD]      <= THR_GOOD_RST;
            thr_reg[REG_THR_FAIR]      <= THR_FAIR_RST;
            thr_reg[REG_THR_INFERIOR]  <= THR_INFERIOR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THR_UNKNOWN:   thr_reg[REG_THR_UNKNOWN]   <= cfg_data;
                REG_THR_EXCELLENT: thr_reg[REG_THR_EXCELLENT] <= cfg_data;
                REG_THR_GOOD:      thr_reg[REG_THR_GOOD]      <= cfg_data;
                REG_THR_FAIR:      thr_reg[REG_THR_FAIR]      <= cfg_data;
                REG_THR_INFERIOR:  thr_reg[REG_THR_INFERIOR]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            b_co2_sum_reg   <= s_read_error ? co2_sum_reg : co2_add;
            b_temp_sum_reg  <= s_read_error ? temp_sum_reg : temp_add;
            b_humid_sum_reg <= s_read_error ? humid_sum_reg : humid_add;
        end
        if (b_move) begin
            m_mean_co2_reg   <= mean_co2;
            m_mean_temp_reg  <= mean_temp;
            m_mean_humid_reg <= mean_humid;
            m_class_reg      <= class_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_mean_co2      = m_mean_co2_reg;
    assign m_mean_temp     = m_mean_temp_reg;
    assign m_mean_humid    = m_mean_humid_reg;
    assign m_quality_class = m_class_reg;
    // peak only moves when a result loads, so it is stable while one waits
    assign m_peak_co2      = peak_reg;

endmodule

// ----- hw/rtl/asac_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for air_sample_averager_classifier, and the bind that
// attaches them. Depends on asac_pkg.
module asac_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [asac_pkg::CO2_W-1:0]            m_mean_co2,
    input logic signed [asac_pkg::TEMP_W-1:0]    m_mean_temp,
    input logic [asac_pkg::HUMID_W-1:0]          m_mean_humid,
    input logic [asac_pkg::CLASS_W-1:0]          m_quality_class,
    input logic [asac_pkg::CO2_W-1:0]            m_peak_co2
);
    import asac_pkg::*;

    // a stalled result request holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_co2) && $stable(m_mean_temp)
            && $stable(m_mean_humid) && $stable(m_quality_class) && $stable(m_peak_co2))
        else $error("result changed while stalled");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quality_class <= CLASS_POOR)
        else $error("class code out of range");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_co2 >= m_mean_co2)
        else $error("peak below the current mean");

    // after reset the pipeline is empty and takes a request at once
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind air_sample_averager_classifier asac_checker u_asac_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_mean_co2      (m_mean_co2),
    .m_mean_temp     (m_mean_temp),
    .m_mean_humid    (m_mean_humid),
    .m_quality_class (m_quality_class),
    .m_peak_co2      (m_peak_co2)
);
